// ----- src/two_class_priority_queue_macros.svh -----
// Assertion macros shared by the two-class priority queue RTL.
`ifndef TWO_CLASS_PRIORITY_QUEUE_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TCPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcpq assertion failed");

// Next-cycle implication, disabled while reset is held.
`define TCPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcpq assertion failed");

`endif

// ----- src/tcpq_pkg.sv -----
// Types and constants for the two-class priority queue.
package tcpq_pkg;

    localparam int KEY_W    = 16;
    localparam int OCC_W    = 5;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [KEY_W-1:0] THRESH_RESET = 16'd60;

    // register index as decoded from paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    // operation broadcast to every cell in the chain
    typedef struct packed {
        logic             ins_en;
        logic             pop_en;
        logic             hi;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

endpackage

// ----- src/tcpq_cell.sv -----
// One queue slot: holds a key, compares it against an insert and shifts with its neighbors.
module tcpq_cell
    import tcpq_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic             i_valid,
    input  logic             i_found,
    input  logic [KEY_W-1:0] i_prev_val,
    input  logic [KEY_W-1:0] i_next_val,
    output logic             o_found,
    output logic [KEY_W-1:0] o_val
);

    logic [KEY_W-1:0] r_val;
    logic             w_match;

    // an empty slot always matches so a low-class key lands at the tail
    assign w_match = i_valid ? (i_ctl.hi && (i_ctl.key > r_val)) : 1'b1;
    assign o_found = i_found | w_match;
    assign o_val   = r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_en) begin
            if (i_found) begin
                r_val <= i_prev_val;
            end else if (w_match) begin
                r_val <= i_ctl.key;
            end
        end else if (i_ctl.pop_en) begin
            r_val <= i_next_val;
        end
    end

endmodule

// ----- src/two_class_priority_queue.sv -----
// Top level of the two-class priority queue: cell chain, count and output register.
//
// Requests arrive on the s_ stream: s_tuser is the request type (0 insert, 1 remove),
// s_tdata the 16-bit key. Each accepted word yields exactly one result word on the
// m_ stream: m_tdata holds removed_value and occupancy, m_tuser the status code.
// Inserts at or above the programmed threshold go ahead of the first stored key that
// is strictly smaller; others are appended. Removes pop the head.
// The result is registered and appears in the cycle after the request is accepted. One request
// per cycle is sustained while m_tready stays high; the insert position is resolved by a
// one-bit ripple through the DEPTH cells, which sets the clock period.
// s_tready is high while the output register is empty or being drained, so a stall
// on m_tready holds one result and then backs up into s_tready.
// Reset empties the queue and sets the threshold to 60; stored keys are not cleared.
// The threshold register sits at APB address 0; write it only while the queue is idle.
module two_class_priority_queue
    import tcpq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [15:0] key
    input  logic                s_tuser,   // [0] req_type
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [15:0] removed_value, [20:16] occupancy, zero pad
    output logic [STATUS_W-1:0] m_tuser,   // [1:0] status
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    `include "two_class_priority_queue_macros.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [KEY_W-1:0]    r_thresh;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_m_valid;
    logic [KEY_W-1:0]    r_rm_val;
    logic [KEY_W-1:0]    n_rm_val;
    t_status             r_status;
    t_status             n_status;
    logic [OCC_W-1:0]    r_occ;

    logic                w_acc;
    logic                w_full;
    logic                w_empty;
    t_cell_ctl           w_ctl;
    logic [KEY_W-1:0]    w_val [DEPTH];
    logic [DEPTH:0]      w_found;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THRESHOLD) ? APB_DW'(r_thresh) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)) begin
            r_thresh <= pwdata[KEY_W-1:0];
        end
    end

    // ---------------- request decode ----------------
    assign s_tready = !r_m_valid || m_tready;
    assign w_acc    = s_tvalid && s_tready;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_ctl.ins_en = w_acc && (s_tuser == REQ_INSERT) && !w_full;
    assign w_ctl.pop_en = w_acc && (s_tuser == REQ_REMOVE) && !w_empty;
    assign w_ctl.key    = s_tdata[KEY_W-1:0];
    assign w_ctl.hi     = (s_tdata[KEY_W-1:0] >= r_thresh);

    // ---------------- cell chain ----------------
    assign w_found[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [KEY_W-1:0] w_prev;
        logic [KEY_W-1:0] w_next;

        if (i == 0) begin : g_head
            assign w_prev = '0;
        end else begin : g_body
            assign w_prev = w_val[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_val[i+1];
        end

        tcpq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_valid    (r_count > CNT_W'(i)),
            .i_found    (w_found[i]),
            .i_prev_val (w_prev),
            .i_next_val (w_next),
            .o_found    (w_found[i+1]),
            .o_val      (w_val[i])
        );
    end

    // ---------------- count and result ----------------
    always_comb begin
        n_count  = r_count;
        n_rm_val = '0;
        n_status = STATUS_OK;
        if (s_tuser == REQ_INSERT) begin
            if (w_full) begin
                n_status = STATUS_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = STATUS_EMPTY;
            end else begin
                n_count  = r_count - CNT_W'(1);
                n_rm_val = w_val[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rm_val <= n_rm_val;
            r_status <= n_status;
            r_occ    <= OCC_W'(n_count);
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {{(M_DATA_W - KEY_W - OCC_W){1'b0}}, r_occ, r_rm_val};
    assign m_tuser  = r_status;

    // ---------------- assertions ----------------
    `TCPQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH))
    `TCPQ_ASSERT_NOW(a_ins_has_slot, w_ctl.ins_en, w_found[DEPTH])
    `TCPQ_ASSERT_NEXT(a_full_drop, w_acc && (s_tuser == REQ_INSERT) && w_full,
        (r_status == STATUS_FULL) && $stable(r_count))
    `TCPQ_ASSERT_NEXT(a_empty_pop, w_acc && (s_tuser == REQ_REMOVE) && w_empty,
        (r_status == STATUS_EMPTY) && (r_rm_val == '0) && (r_count == '0))

endmodule
